// File: rtl/core/gsm_pkg.sv
// Shared types and constants for the gamepad slot mapper.
package gsm_pkg;

    localparam int GSM_SLOTS   = 4;
    localparam int SHOWN_SLOTS = 4;
    localparam int ID_W        = 32;
    localparam int BTN_W       = 8;
    localparam int OP_W        = 2;
    localparam int COUNT_W     = 3;
    localparam int COUNT_MAX   = 7;

    typedef enum logic [OP_W-1:0] {
        OP_JOIN   = 2'd0,
        OP_REMOVE = 2'd1,
        OP_BUTTON = 2'd2,
        OP_FLUSH  = 2'd3
    } opcode_t;

    typedef struct packed {
        opcode_t              opcode;
        logic [ID_W-1:0]      device_id;
        logic [BTN_W-1:0]     button_mask;
        logic                 is_down;
    } item_t;

    typedef struct packed {
        logic [SHOWN_SLOTS-1:0][BTN_W-1:0] held;
        logic [SHOWN_SLOTS-1:0][BTN_W-1:0] latched;
        logic [COUNT_W-1:0]                occupied_count;
    } result_t;

endpackage

// File: rtl/core/gsm_req_if.sv
// Request channel: one slot-table event per transfer.
interface gsm_req_if;
    import gsm_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [ID_W-1:0]   device_id;
    logic [BTN_W-1:0]  button_mask;
    logic              is_down;

    modport source (output valid, opcode, device_id, button_mask, is_down, input ready);
    modport sink   (input valid, opcode, device_id, button_mask, is_down, output ready);
endinterface

// File: rtl/core/gsm_rsp_if.sv
// Response channel: per-slot held and latched masks plus occupied count.
interface gsm_rsp_if;
    import gsm_pkg::*;

    logic                valid;
    logic                ready;
    logic [BTN_W-1:0]    held_slot0;
    logic [BTN_W-1:0]    held_slot1;
    logic [BTN_W-1:0]    held_slot2;
    logic [BTN_W-1:0]    held_slot3;
    logic [BTN_W-1:0]    latched_slot0;
    logic [BTN_W-1:0]    latched_slot1;
    logic [BTN_W-1:0]    latched_slot2;
    logic [BTN_W-1:0]    latched_slot3;
    logic [COUNT_W-1:0]  occupied_count;

    modport source (output valid, held_slot0, held_slot1, held_slot2, held_slot3,
                    latched_slot0, latched_slot1, latched_slot2, latched_slot3,
                    occupied_count, input ready);
    modport sink   (input valid, held_slot0, held_slot1, held_slot2, held_slot3,
                    latched_slot0, latched_slot1, latched_slot2, latched_slot3,
                    occupied_count, output ready);
endinterface

// File: rtl/core/gsm_slot_logic.sv
// Next-state and result logic of the slot table for one event.
module gsm_slot_logic
    import gsm_pkg::*;
#(
    parameter int SLOTS = GSM_SLOTS
)
(
    input  logic [SLOTS-1:0][ID_W-1:0]  owner,
    input  logic [SLOTS-1:0][BTN_W-1:0] held,
    input  logic [SLOTS-1:0][BTN_W-1:0] latch,
    input  item_t                       item,
    output logic [SLOTS-1:0][ID_W-1:0]  owner_next,
    output logic [SLOTS-1:0][BTN_W-1:0] held_next,
    output logic [SLOTS-1:0][BTN_W-1:0] latch_next,
    output result_t                     result
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int SUM_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    logic [SHOWN_SLOTS-1:0][BTN_W-1:0] held_show;
    logic [SHOWN_SLOTS-1:0][BTN_W-1:0] latch_show;
    logic [COUNT_W-1:0]                count_sat;

    always_comb
    begin
        logic                          found;
        logic [CNT_W-1:0]              pos;
        logic [SLOTS-1:0][ID_W-1:0]    cleared;

        owner_next = owner;
        held_next  = held;
        latch_next = latch;
        found      = 1'b0;
        pos        = '0;
        cleared    = owner;

        case (item.opcode)
            OP_JOIN:
            begin
                // take the first empty slot
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!found && owner[i] == '0)
                    begin
                        owner_next[i] = item.device_id;
                        found         = 1'b1;
                    end
                end
            end
            OP_REMOVE:
            begin
                // clear first match, then pack nonzero ids to the front in order
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!found && owner[i] == item.device_id)
                    begin
                        cleared[i] = '0;
                        found      = 1'b1;
                    end
                end
                owner_next = '0;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (cleared[i] != '0)
                    begin
                        owner_next[pos[IDX_W-1:0]] = cleared[i];
                        pos = pos + CNT_W'(1);
                    end
                end
            end
            OP_BUTTON:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!found && owner[i] == item.device_id)
                    begin
                        if (item.is_down)
                        begin
                            held_next[i]  = held[i] | item.button_mask;
                            latch_next[i] = latch[i] | item.button_mask;
                        end
                        else
                        begin
                            held_next[i] = held[i] & ~item.button_mask;
                        end
                        found = 1'b1;
                    end
                end
            end
            OP_FLUSH:
            begin
                latch_next = '0;
            end
            default:
            begin
                owner_next = owner;
            end
        endcase
    end

    always_comb
    begin
        logic [SUM_W-1:0] cnt;

        cnt = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (owner_next[i] != '0)
            begin
                cnt = cnt + SUM_W'(1);
            end
        end
        if (cnt > SUM_W'(COUNT_MAX))
        begin
            count_sat = COUNT_W'(COUNT_MAX);
        end
        else
        begin
            count_sat = cnt[COUNT_W-1:0];
        end
    end

    // slots past the table read as zero; slots past the shown range are dropped
    for (genvar g = 0; g < SHOWN_SLOTS; g++)
    begin : g_show
        if (g < SLOTS)
        begin : g_live
            assign held_show[g]  = held_next[g];
            assign latch_show[g] = latch_next[g];
        end
        else
        begin : g_none
            assign held_show[g]  = '0;
            assign latch_show[g] = '0;
        end
    end

    assign result.held           = held_show;
    assign result.latched        = latch_show;
    assign result.occupied_count = count_sat;

endmodule

// File: rtl/core/gamepad_slot_mapper_with_latches.sv
// Top level of the gamepad slot mapper with held and pressed latches.
//
// Usage:
//   req carries one event per transfer: opcode (join, remove, button, flush),
//   device_id, button_mask and is_down. rsp returns one result per event:
//   held and latched masks of slots 0..3 and the occupied count, all taken
//   after the event has been applied to the slot table.
// Pipeline and throughput:
//   An event is registered in the input register at its transfer and is
//   applied to the slot table when it advances into the result register,
//   where its result is registered and rsp.valid rises with it.
//   One event per cycle is sustained while rsp.ready stays high: the input register
//   advances into the result register whenever that register is empty or
//   its result is taken in the same cycle, and the search and compaction
//   logic between the two registers is combinational.
// Reset:
//   rst_n clears the slot table, all held and latched masks and both valid
//   flags; no warm-up is needed after reset.
// Stall:
//   While rsp.ready is low the result stays put and one more event can wait
//   in the input register; req.ready drops once both registers are full.
module gamepad_slot_mapper_with_latches
    import gsm_pkg::*;
#(
    parameter int SLOTS = GSM_SLOTS
)
(
    input  logic          clk,
    input  logic          rst_n,
    gsm_req_if.sink       req,
    gsm_rsp_if.source     rsp
);

    localparam int SHOW_MAX = (SLOTS > COUNT_MAX) ? COUNT_MAX : SLOTS;

    // input stage
    logic                        in_valid_reg;
    item_t                       item_reg;

    // slot table state
    logic [SLOTS-1:0][ID_W-1:0]  owner_reg;
    logic [SLOTS-1:0][BTN_W-1:0] held_reg;
    logic [SLOTS-1:0][BTN_W-1:0] latch_reg;
    logic [SLOTS-1:0][ID_W-1:0]  owner_next;
    logic [SLOTS-1:0][BTN_W-1:0] held_next;
    logic [SLOTS-1:0][BTN_W-1:0] latch_next;

    // result stage
    logic                        out_valid_reg;
    result_t                     rsp_reg;
    result_t                     rsp_next;

    logic                        advance;
    logic                        req_fire;
    logic                        table_compact;

    // move the held event forward when the result slot frees up this cycle
    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign req_fire  = req.valid && req.ready;

    gsm_slot_logic #(
        .SLOTS (SLOTS)
    ) u_slot_logic (
        .owner      (owner_reg),
        .held       (held_reg),
        .latch      (latch_reg),
        .item       (item_reg),
        .owner_next (owner_next),
        .held_next  (held_next),
        .latch_next (latch_next),
        .result     (rsp_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            owner_reg     <= '0;
            held_reg      <= '0;
            latch_reg     <= '0;
        end
        else
        begin
            if (req_fire)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                owner_reg     <= owner_next;
                held_reg      <= held_next;
                latch_reg     <= latch_next;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers: item loads on req transfer, result on advance; hold otherwise
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            item_reg.opcode      <= opcode_t'(req.opcode);
            item_reg.device_id   <= req.device_id;
            item_reg.button_mask <= req.button_mask;
            item_reg.is_down     <= req.is_down;
        end
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.held_slot0     = rsp_reg.held[0];
    assign rsp.held_slot1     = rsp_reg.held[1];
    assign rsp.held_slot2     = rsp_reg.held[2];
    assign rsp.held_slot3     = rsp_reg.held[3];
    assign rsp.latched_slot0  = rsp_reg.latched[0];
    assign rsp.latched_slot1  = rsp_reg.latched[1];
    assign rsp.latched_slot2  = rsp_reg.latched[2];
    assign rsp.latched_slot3  = rsp_reg.latched[3];
    assign rsp.occupied_count = rsp_reg.occupied_count;

    // the table never has an empty slot ahead of an occupied one
    always_comb
    begin
        table_compact = 1'b1;
        for (int i = 0; i < SLOTS - 1; i++)
        begin
            if (owner_reg[i] == '0 && owner_reg[i+1] != '0)
            begin
                table_compact = 1'b0;
            end
        end
    end

    a_table_compact: assert property (@(posedge clk) disable iff (!rst_n)
        table_compact)
        else $error("slot table has a gap ahead of an occupied slot");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> rsp_reg.occupied_count <= COUNT_W'(SHOW_MAX))
        else $error("occupied count exceeds slot count");

    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced event produced no result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |-> !advance)
        else $error("stalled result overwritten");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && item_reg.opcode == OP_FLUSH) |=> (latch_reg == '0 && rsp_reg.latched == '0))
        else $error("flush left latch bits set");

endmodule

// File: tb/gamepad_slot_mapper_with_latches_tb.sv
// Self-checking testbench for the gamepad slot mapper: directed and random events, checked per slot.
module gamepad_slot_mapper_with_latches_tb;
    import gsm_pkg::*;

    // Generous bound: ~2000 events, each at worst waiting out a sender gap and a
    // long receiver stall, plus the drain pauses. A correct run needs far less.
    localparam int LIMIT_CYCLES   = 400000;
    localparam int RANDOM_EVENTS  = 1950;
    localparam int POOL_SIZE      = 6;
    localparam int MAX_PRINTED    = 40;

    // Tracks the slot table, held and latch masks, and queues the view that
    // each accepted event must produce.
    class slot_table_tracker;
        logic [ID_W-1:0]  owner [GSM_SLOTS];
        logic [BTN_W-1:0] held  [GSM_SLOTS];
        logic [BTN_W-1:0] latch [GSM_SLOTS];
        result_t          pending_views [$];
        int               errors;
        int               checked;
        int               full_joins;
        int               peak_count;
        int               op_seen [4];

        function new();
            foreach (owner[i])
            begin
                owner[i] = '0;
                held[i]  = '0;
                latch[i] = '0;
            end
            foreach (op_seen[i])
                op_seen[i] = 0;
            errors     = 0;
            checked    = 0;
            full_joins = 0;
            peak_count = 0;
        endfunction

        function void note_event(item_t it);
            int              hit;
            int              n;
            int              count;
            logic [ID_W-1:0] compact_ids [GSM_SLOTS];
            result_t         view;

            hit = -1;
            op_seen[int'(it.opcode)]++;
            case (it.opcode)
                OP_JOIN:
                begin
                    for (int i = 0; i < GSM_SLOTS; i++)
                        if (hit < 0 && owner[i] == '0)
                            hit = i;
                    if (hit >= 0)
                        owner[hit] = it.device_id;
                    else
                        full_joins++;
                end
                OP_REMOVE:
                begin
                    for (int i = 0; i < GSM_SLOTS; i++)
                        if (hit < 0 && owner[i] == it.device_id)
                            hit = i;
                    if (hit >= 0)
                        owner[hit] = '0;
                    // stable compaction of ids only; masks keep their slot index
                    n = 0;
                    foreach (compact_ids[i])
                        compact_ids[i] = '0;
                    for (int i = 0; i < GSM_SLOTS; i++)
                        if (owner[i] != '0)
                        begin
                            compact_ids[n] = owner[i];
                            n++;
                        end
                    foreach (owner[i])
                        owner[i] = compact_ids[i];
                end
                OP_BUTTON:
                begin
                    // id 0 matches the first empty slot, like any other id
                    for (int i = 0; i < GSM_SLOTS; i++)
                        if (hit < 0 && owner[i] == it.device_id)
                            hit = i;
                    if (hit >= 0)
                    begin
                        if (it.is_down)
                        begin
                            held[hit]  = held[hit] | it.button_mask;
                            latch[hit] = latch[hit] | it.button_mask;
                        end
                        else
                            held[hit] = held[hit] & ~it.button_mask;
                    end
                end
                default:
                    foreach (latch[i])
                        latch[i] = '0;
            endcase

            for (int i = 0; i < SHOWN_SLOTS; i++)
            begin
                view.held[i]    = (i < GSM_SLOTS) ? held[i]  : '0;
                view.latched[i] = (i < GSM_SLOTS) ? latch[i] : '0;
            end
            count = 0;
            foreach (owner[i])
                if (owner[i] != '0)
                    count++;
            if (count > peak_count)
                peak_count = count;
            if (count > COUNT_MAX)
                count = COUNT_MAX;
            view.occupied_count = count[COUNT_W-1:0];
            pending_views.push_back(view);
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTED)
                $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_view(result_t got);
            result_t want;

            if (pending_views.size() == 0)
            begin
                report("result transfer with no event outstanding");
                return;
            end
            want = pending_views.pop_front();
            checked++;
            for (int i = 0; i < SHOWN_SLOTS; i++)
            begin
                if (got.held[i] !== want.held[i])
                    report($sformatf("result %0d slot %0d held: got %02h, wanted %02h",
                                     checked, i, got.held[i], want.held[i]));
                if (got.latched[i] !== want.latched[i])
                    report($sformatf("result %0d slot %0d latched: got %02h, wanted %02h",
                                     checked, i, got.latched[i], want.latched[i]));
            end
            if (got.occupied_count !== want.occupied_count)
                report($sformatf("result %0d occupied_count: got %0d, wanted %0d",
                                 checked, got.occupied_count, want.occupied_count));
        endtask
    endclass

    logic clk;
    logic rst_n;

    gsm_req_if req_ch ();
    gsm_rsp_if rsp_ch ();

    gamepad_slot_mapper_with_latches #(
        .SLOTS (GSM_SLOTS)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    slot_table_tracker tracker = new();

    int              burst_left = 0;
    int              cycles     = 0;
    logic [ID_W-1:0] id_pool [POOL_SIZE];

    initial
    begin
        clk = 1'b0;
        forever
            #2 clk = ~clk;
    end

    // Watchdog: stop a hung run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, tracker.pending_views.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver: run through phases of always-ready, coin-flip, mostly-ready and
    // mostly-stalled, each of random length, so stalls land on every pipeline phase.
    initial
    begin
        int  mode;
        int  run;
        logic take;

        rsp_ch.ready <= 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            run  = $urandom_range(16, 160);
            repeat (run)
            begin
                @(posedge clk);
                case (mode)
                    0:       take = 1'b1;
                    1:       take = 1'($urandom_range(0, 1));
                    2:       take = ($urandom_range(0, 7) != 0);
                    default: take = ($urandom_range(0, 5) == 0);
                endcase
                rsp_ch.ready <= take;
            end
        end
    end

    // Result monitor: values read here are the ones present at the edge.
    always @(posedge clk)
    begin
        result_t got;

        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.held[0]        = rsp_ch.held_slot0;
            got.held[1]        = rsp_ch.held_slot1;
            got.held[2]        = rsp_ch.held_slot2;
            got.held[3]        = rsp_ch.held_slot3;
            got.latched[0]     = rsp_ch.latched_slot0;
            got.latched[1]     = rsp_ch.latched_slot1;
            got.latched[2]     = rsp_ch.latched_slot2;
            got.latched[3]     = rsp_ch.latched_slot3;
            got.occupied_count = rsp_ch.occupied_count;
            tracker.check_view(got);
        end
    end

    function automatic item_t make_event(opcode_t op, logic [ID_W-1:0] id,
                                         logic [BTN_W-1:0] mask, logic down);
        item_t it;

        it.opcode      = op;
        it.device_id   = id;
        it.button_mask = mask;
        it.is_down     = down;
        return it;
    endfunction

    // Pick an id: mostly from the small pool so joins, removes and buttons hit
    // each other; sometimes 0 or a fully random handle as noise.
    function automatic logic [ID_W-1:0] pick_id(int hit_pct);
        int r;

        r = $urandom_range(0, 99);
        if (r < hit_pct)
            return id_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (r < hit_pct + (100 - hit_pct) / 2)
            return '0;
        else
            return $urandom();
    endfunction

    function automatic item_t random_event();
        int r;

        r = $urandom_range(0, 99);
        if (r < 25)
            return make_event(OP_JOIN, pick_id(90), BTN_W'($urandom()),
                              1'($urandom_range(0, 1)));
        else if (r < 45)
            return make_event(OP_REMOVE, pick_id(85), BTN_W'($urandom()),
                              1'($urandom_range(0, 1)));
        else if (r < 90)
            return make_event(OP_BUTTON, pick_id(85), BTN_W'($urandom()),
                              1'($urandom_range(0, 1)));
        else
            return make_event(OP_FLUSH, $urandom(), BTN_W'($urandom()),
                              1'($urandom_range(0, 1)));
    endfunction

    // Send one event. Bursts of random length, each opened by a gap with valid
    // low, so valid is never lowered and raised in the same step.
    task automatic push_event(input item_t it);
        if (burst_left == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8))
                @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        req_ch.valid       <= 1'b1;
        req_ch.opcode      <= it.opcode;
        req_ch.device_id   <= it.device_id;
        req_ch.button_mask <= it.button_mask;
        req_ch.is_down     <= it.is_down;
        do
            @(posedge clk);
        while (!req_ch.ready);
        tracker.note_event(it);
        burst_left--;
    endtask

    // Hold the sender off until every outstanding result has been taken.
    task automatic hold_until_drained();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending_views.size() != 0);
        burst_left = 0;
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.opcode      <= OP_JOIN;
        req_ch.device_id   <= '0;
        req_ch.button_mask <= '0;
        req_ch.is_down     <= 1'b0;

        foreach (id_pool[i])
            id_pool[i] = $urandom() | 32'h1;
        id_pool[0] = 32'hFFFF_FFFF;
        id_pool[1] = 32'h0000_0001;

        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-table corner cases first.
        push_event(make_event(OP_JOIN,   32'h0,         8'hFF, 1'b1)); // join of id 0: no change
        push_event(make_event(OP_BUTTON, 32'h0,         8'hFF, 1'b1)); // id 0 hits empty slot 0
        push_event(make_event(OP_BUTTON, 32'h0,         8'h0F, 1'b0)); // release part of it
        push_event(make_event(OP_FLUSH,  32'hFFFF_FFFF, 8'h00, 1'b0));
        push_event(make_event(OP_REMOVE, 32'h0,         8'h00, 1'b0)); // remove of id 0: no change
        push_event(make_event(OP_REMOVE, 32'h0000_1234, 8'h00, 1'b0)); // absent id
        // Fill the table, then overflow it.
        push_event(make_event(OP_JOIN,   32'hFFFF_FFFF, 8'h00, 1'b0));
        push_event(make_event(OP_JOIN,   32'h0000_0001, 8'h00, 1'b0));
        push_event(make_event(OP_JOIN,   32'hA5A5_A5A5, 8'h00, 1'b0));
        push_event(make_event(OP_JOIN,   32'h5A5A_5A5A, 8'h00, 1'b0));
        push_event(make_event(OP_JOIN,   32'h0000_0077, 8'h00, 1'b0)); // full table: ignored
        push_event(make_event(OP_BUTTON, 32'h0,         8'hFF, 1'b1)); // no empty slot: ignored
        // Buttons on every slot, then a release and an unmatched id.
        push_event(make_event(OP_BUTTON, 32'hFFFF_FFFF, 8'hFF, 1'b1));
        push_event(make_event(OP_BUTTON, 32'h0000_0001, 8'h80, 1'b1));
        push_event(make_event(OP_BUTTON, 32'hA5A5_A5A5, 8'h01, 1'b1));
        push_event(make_event(OP_BUTTON, 32'h5A5A_5A5A, 8'h55, 1'b1));
        push_event(make_event(OP_BUTTON, 32'h5A5A_5A5A, 8'h05, 1'b0));
        push_event(make_event(OP_BUTTON, 32'h0000_0099, 8'hFF, 1'b1)); // no match: ignored
        // Removes: middle slot forces compaction while masks stay put.
        push_event(make_event(OP_REMOVE, 32'h0000_0001, 8'h00, 1'b0));
        push_event(make_event(OP_REMOVE, 32'h0000_DEAD, 8'h00, 1'b0));
        push_event(make_event(OP_FLUSH,  32'h0,         8'hFF, 1'b1));
        push_event(make_event(OP_REMOVE, 32'hFFFF_FFFF, 8'h00, 1'b0)); // first slot
        push_event(make_event(OP_REMOVE, 32'h5A5A_5A5A, 8'h00, 1'b0)); // last occupied
        push_event(make_event(OP_BUTTON, 32'h0,         8'h3C, 1'b1)); // id 0 hits first empty
        push_event(make_event(OP_REMOVE, 32'hA5A5_A5A5, 8'h00, 1'b0)); // back to empty
        hold_until_drained();

        // Random: pooled ids keep the table busy; a drain pause now and then.
        for (int i = 0; i < RANDOM_EVENTS; i++)
        begin
            push_event(random_event());
            if (i % 500 == 499)
                hold_until_drained();
        end

        req_ch.valid <= 1'b0;
        while (tracker.pending_views.size() != 0)
            @(posedge clk);
        // Two-stage pipeline: keep clocking so any stray result would still show up.
        repeat (10)
            @(posedge clk);

        $display("Covered %0d events (join %0d, remove %0d, button %0d, flush %0d), %0d results",
                 tracker.op_seen[0] + tracker.op_seen[1] + tracker.op_seen[2]
                 + tracker.op_seen[3], tracker.op_seen[0], tracker.op_seen[1],
                 tracker.op_seen[2], tracker.op_seen[3], tracker.checked);
        $display("Joins turned away by a full table: %0d, peak occupancy %0d of %0d slots",
                 tracker.full_joins, tracker.peak_count, GSM_SLOTS);
        if (tracker.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
